@@ design/cspp_pkg.sv @@
// ---------------------------------------------------------------------------
// Crypt surface point projector package
// Shared widths, register indexes, region and part codes.
// ---------------------------------------------------------------------------
package cspp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RW          = 31;
  localparam int KW          = RW + 1;
  localparam int MUL_SPLIT   = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int REGION_W    = 3;
  localparam int PART_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRYPT_LENGTH = 2'd1;

  localparam logic [RW-1:0] BASE_RADIUS_RESET  = 31'd65536;
  localparam logic [RW-1:0] CRYPT_LENGTH_RESET = 31'd131072;

  localparam logic [REGION_W-1:0] REGION_CRYPT1 = 3'd0;
  localparam logic [REGION_W-1:0] REGION_CRYPT2 = 3'd1;
  localparam logic [REGION_W-1:0] REGION_CRYPT3 = 3'd2;
  localparam logic [REGION_W-1:0] REGION_CRYPT4 = 3'd3;
  localparam logic [REGION_W-1:0] REGION_VILLUS = 3'd4;
  localparam logic [REGION_W-1:0] REGION_FLAT   = 3'd5;

  localparam logic [PART_W-1:0] PART_CAP  = 2'd0;
  localparam logic [PART_W-1:0] PART_CYL  = 2'd1;
  localparam logic [PART_W-1:0] PART_RIM  = 2'd2;
  localparam logic [PART_W-1:0] PART_FLAT = 2'd3;

endpackage

@@ design/cspp_if.sv @@
// ---------------------------------------------------------------------------
// Crypt surface point projector channels
// Point input, surface result and configuration write channels.
// ---------------------------------------------------------------------------
interface cspp_point_if #(parameter int CW = cspp_pkg::COORD_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface cspp_surf_if #(parameter int CW = cspp_pkg::COORD_WIDTH);
  logic                            valid;
  logic                            ready;
  logic signed [CW-1:0]            surf_x;
  logic signed [CW-1:0]            surf_y;
  logic signed [CW-1:0]            surf_z;
  logic [cspp_pkg::REGION_W-1:0]   region;
  logic [cspp_pkg::PART_W-1:0]     part;
  logic                            degenerate;
  modport source (output valid, surf_x, surf_y, surf_z, region, part, degenerate,
                  input ready);
  modport sink   (input valid, surf_x, surf_y, surf_z, region, part, degenerate,
                  output ready);
endinterface

interface cspp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cspp_pkg::CFG_IDX_W-1:0]  index;
  logic [cspp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/cspp_proj.sv @@
// ---------------------------------------------------------------------------
// Radial projection pipeline
// Per lane sign(d) * floor(k * |d| / floor(sqrt(|d|^2))), with split
// multipliers, one root bit and one quotient bit per stage.
// ---------------------------------------------------------------------------
module cspp_proj #(
  parameter int DW  = cspp_pkg::COORD_WIDTH + 5,
  parameter int PLW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DW-1:0]         d [3],
  input  logic [cspp_pkg::KW-1:0]      k,
  input  logic [PLW-1:0]               in_pl,
  output logic                         out_valid,
  output logic signed [cspp_pkg::KW:0] q [3],
  output logic                         zero,
  output logic [PLW-1:0]               out_pl
);

  localparam int KW = cspp_pkg::KW;
  localparam int LB = cspp_pkg::MUL_SPLIT;
  localparam int MW = DW - 1;
  localparam int HB = MW - LB;
  localparam int NW = MW + 1;
  localparam int SW = 2 * NW;
  localparam int PW = KW + MW;
  localparam int QW = KW;

  logic             va;
  logic [MW-1:0]    ma [3];
  logic [2:0]       sa;
  logic [KW-1:0]    ka;
  logic [PLW-1:0]   pla;

  logic             vb;
  logic [MW+LB-1:0] sq_lo [3];
  logic [MW+HB-1:0] sq_hi [3];
  logic [KW+LB-1:0] kp_lo [3];
  logic [KW+HB-1:0] kp_hi [3];
  logic [2:0]       sb;
  logic [PLW-1:0]   plb;

  logic             vc;
  logic [2*MW-1:0]  sq [3];
  logic [PW-1:0]    pr [3];
  logic [2:0]       sc;
  logic [PLW-1:0]   plc;

  logic             sq_v    [NW+1];
  logic [SW-1:0]    sq_val  [NW+1];
  logic [NW:0]      sq_rem  [NW+1];
  logic [NW-1:0]    sq_root [NW+1];
  logic [PW-1:0]    sq_pr   [NW+1][3];
  logic [2:0]       sq_sgn  [NW+1];
  logic [PLW-1:0]   sq_pl   [NW+1];

  logic             dv_v    [QW];
  logic [NW-1:0]    dv_rem  [QW][3];
  logic [QW-1:0]    dv_nl   [QW][3];
  logic [QW-1:0]    dv_q    [QW][3];
  logic [NW-1:0]    dv_n    [QW];
  logic [2:0]       dv_sgn  [QW];
  logic [PLW-1:0]   dv_pl   [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      sq_v[0] <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ma[c] <= MW'(d[c][DW-1] ? -d[c] : d[c]);
        sa[c] <= d[c][DW-1];
        sq_lo[c] <= ma[c] * ma[c][LB-1:0];
        sq_hi[c] <= ma[c] * ma[c][MW-1:LB];
        kp_lo[c] <= ka * ma[c][LB-1:0];
        kp_hi[c] <= ka * ma[c][MW-1:LB];
        sq[c] <= (2*MW)'(sq_lo[c]) + ((2*MW)'(sq_hi[c]) << LB);
        pr[c] <= PW'(kp_lo[c]) + (PW'(kp_hi[c]) << LB);
      end
      ka <= k;
      pla <= in_pl;
      sb <= sa;
      plb <= pla;
      sc <= sb;
      plc <= plb;
      sq_val[0] <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      sq_pr[0] <= pr;
      sq_sgn[0] <= sc;
      sq_pl[0] <= plc;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_sqrt
    logic [NW+2:0] r2;
    logic [NW+2:0] tr;
    logic          ge;

    assign r2 = {sq_rem[i], sq_val[i][SW-1 -: 2]};
    assign tr = (NW+3)'({sq_root[i], 2'b01});
    assign ge = (r2 >= tr);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[i+1] <= (NW+1)'(ge ? r2 - tr : r2);
        sq_root[i+1] <= {sq_root[i][NW-2:0], ge};
        sq_val[i+1] <= sq_val[i] << 2;
        sq_pr[i+1] <= sq_pr[i];
        sq_sgn[i+1] <= sq_sgn[i];
        sq_pl[i+1] <= sq_pl[i];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [NW-1:0]  rem_i [3];
    logic [QW-1:0]  nl_i  [3];
    logic [QW-1:0]  q_i   [3];
    logic [NW-1:0]  n_i;
    logic [2:0]     sgn_i;
    logic [PLW-1:0] pl_i;
    logic           v_i;
    logic [NW:0]    t     [3];
    logic [2:0]     ge;

    if (j == 0) begin : g_first
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          rem_i[c] = NW'(sq_pr[NW][c][PW-1:QW]);
          nl_i[c] = sq_pr[NW][c][QW-1:0];
          q_i[c] = '0;
        end
      end
      assign n_i = sq_root[NW];
      assign sgn_i = sq_sgn[NW];
      assign pl_i = sq_pl[NW];
      assign v_i = sq_v[NW];
    end else begin : g_next
      assign rem_i = dv_rem[j-1];
      assign nl_i = dv_nl[j-1];
      assign q_i = dv_q[j-1];
      assign n_i = dv_n[j-1];
      assign sgn_i = dv_sgn[j-1];
      assign pl_i = dv_pl[j-1];
      assign v_i = dv_v[j-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        t[c] = {rem_i[c], nl_i[c][QW-1]};
        ge[c] = (t[c] >= {1'b0, n_i});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (en) begin
        dv_v[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          dv_rem[j][c] <= NW'(ge[c] ? t[c] - {1'b0, n_i} : t[c]);
          dv_nl[j][c] <= nl_i[c] << 1;
          dv_q[j][c] <= {q_i[c][QW-2:0], ge[c]};
        end
        dv_n[j] <= n_i;
        dv_sgn[j] <= sgn_i;
        dv_pl[j] <= pl_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        q[c] <= dv_sgn[QW-1][c] ? -$signed({1'b0, dv_q[QW-1][c]})
                                :  $signed({1'b0, dv_q[QW-1][c]});
      end
      zero <= (dv_n[QW-1] == '0);
      out_pl <= dv_pl[QW-1];
    end
  end

endmodule

@@ design/crypt_surface_point_projector_core.sv @@
// ---------------------------------------------------------------------------
// Crypt surface point projector
// Projects a Q16.16 point onto four crypts, one villus and a flat plane.
//
//   channel  dir  payload
//   cfg      in   index, data (base_radius, crypt_length)
//   point    in   pos_x, pos_y, pos_z
//   surf     out  surf_x, surf_y, surf_z, region, part, degenerate
//
// One transaction per cycle in and out while surf is ready, with
// DW = max(COORD_WIDTH,35)+2. Two radial projection pipelines do the
// work: one root bit, then one quotient bit, per stage.
// Reset clears valid bits and loads R = 1.0, L = 2.0. A stall at surf freezes
// the whole pipeline; cfg is always ready.
// ---------------------------------------------------------------------------
module crypt_surface_point_projector_core #(
  parameter int COORD_WIDTH = cspp_pkg::COORD_WIDTH
) (
  input logic          clk,
  input logic          rst,
  cspp_cfg_if.sink     cfg,
  cspp_point_if.sink   point,
  cspp_surf_if.source  surf
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = ((CW > 35) ? CW : 35) + 2;
  localparam int RW   = cspp_pkg::RW;
  localparam int KW   = cspp_pkg::KW;
  localparam int GW   = cspp_pkg::REGION_W;
  localparam int TW   = cspp_pkg::PART_W;
  localparam int PLW1 = 3 * CW + GW + TW + 1;
  localparam int PLW2 = PLW1 + 3 * (KW + 1) + 1;

  function automatic logic signed [DW-1:0] axis_pos(
    input logic [GW-1:0]        rg,
    input logic                 ydir,
    input logic signed [DW-1:0] a2,
    input logic signed [DW-1:0] a6,
    input logic signed [DW-1:0] a10
  );
    logic far;
    far = ydir ? (rg == cspp_pkg::REGION_CRYPT3 || rg == cspp_pkg::REGION_CRYPT4)
               : (rg == cspp_pkg::REGION_CRYPT2 || rg == cspp_pkg::REGION_CRYPT4);
    if (rg == cspp_pkg::REGION_VILLUS) begin
      return a6;
    end else if (rg > cspp_pkg::REGION_VILLUS) begin
      return '0;
    end
    return far ? a10 : a2;
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = DW'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - DW'(1);
    if (v > hi) begin
      return CW'(hi);
    end else if (v < lo) begin
      return CW'(lo);
    end
    return CW'(v);
  endfunction

  logic [RW-1:0] base_radius;
  logic [RW-1:0] crypt_length;

  logic signed [DW-1:0] r1, r2, r3, r6, r10, lw;
  logic signed [DW-1:0] flat_z, czv, rzc, rzv;
  logic [KW-1:0]        kr, k2r;
  logic                 en;
  logic                 o_v;

  logic                 v1, v2, v3, v4, v5, v6;
  logic signed [CW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic signed [CW-1:0] x4, y4, z4, x5, y5, z5, x6, y6, z6;
  logic signed [DW-1:0] hx2 [5];
  logic signed [DW-1:0] hy2 [5];
  logic signed [DW-1:0] ahx [5];
  logic signed [DW-1:0] ahy [5];
  logic [4:0]           box3, box4, in_disc;
  logic [KW-1:0]        mx3 [5];
  logic [KW-1:0]        my3 [5];
  logic [2*KW-1:0]      sx4 [5];
  logic [2*KW-1:0]      sy4 [5];
  logic [2*KW-1:0]      lim4;
  logic [GW-1:0]        reg_sel, reg5, reg6;
  logic                 hit_sel, hit5, hit6;
  logic                 villus5, cap5, cyl5;
  logic signed [DW-1:0] zs5;
  logic [TW-1:0]        part_sel, part6;

  logic signed [DW-1:0] cx6, cy6, cz6;
  logic signed [DW-1:0] d1 [3];
  logic [KW-1:0]        k1;
  logic [PLW1-1:0]      pl1_in;

  logic                 v7;
  logic signed [KW:0]   q7 [3];
  logic                 zero7;
  logic [PLW1-1:0]      pl7;
  logic signed [CW-1:0] x7, y7, z7;
  logic [GW-1:0]        reg7;
  logic signed [DW-1:0] rx7, ry7, rz7;
  logic signed [DW-1:0] d2 [3];
  logic [PLW2-1:0]      pl2_in;

  logic                 v8;
  logic signed [KW:0]   q8 [3];
  logic                 zero8;
  logic [PLW2-1:0]      pl8;
  logic signed [CW-1:0] x8, y8, z8;
  logic [GW-1:0]        reg8;
  logic [TW-1:0]        part8;
  logic                 hit8;
  logic signed [KW:0]   q1x8, q1y8, q1z8;
  logic                 zero1_8;
  logic signed [DW-1:0] cx8, cy8, cz8, rz8, rx8, ry8;
  logic                 degen8;
  logic signed [DW-1:0] ox, oy, oz;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_radius <= cspp_pkg::BASE_RADIUS_RESET;
      crypt_length <= cspp_pkg::CRYPT_LENGTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        cspp_pkg::REG_BASE_RADIUS:  base_radius <= cfg.data[RW-1:0];
        cspp_pkg::REG_CRYPT_LENGTH: crypt_length <= cfg.data[RW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign r1 = DW'(base_radius);
  assign lw = DW'(crypt_length);
  assign r2 = r1 <<< 1;
  assign r3 = r1 + r2;
  assign r6 = r3 <<< 1;
  assign r10 = (r1 <<< 3) + r2;
  assign flat_z = r2 + lw;
  assign czv = (lw <<< 1) + r3;
  assign rzc = r1 + lw;
  assign rzv = r3 + lw;
  assign kr = {1'b0, base_radius};
  assign k2r = {base_radius, 1'b0};

  assign en = !o_v || surf.ready;
  assign point.ready = en;
  assign surf.valid = o_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= point.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      ahx[k] = hx2[k][DW-1] ? -hx2[k] : hx2[k];
      ahy[k] = hy2[k][DW-1] ? -hy2[k] : hy2[k];
      in_disc[k] = box4[k] && (((2*KW+1)'(sx4[k]) + (2*KW+1)'(sy4[k]))
                               < (2*KW+1)'(lim4));
    end
    reg_sel = cspp_pkg::REGION_FLAT;
    hit_sel = 1'b0;
    for (int k = 4; k >= 0; k--) begin
      if (in_disc[k]) begin
        reg_sel = GW'(k);
        hit_sel = 1'b1;
      end
    end
  end

  always_comb begin
    villus5 = (reg5 == cspp_pkg::REGION_VILLUS);
    zs5 = DW'(z5);
    cap5 = villus5 ? (zs5 >= czv) : (zs5 <= r1);
    cyl5 = villus5 ? (zs5 < czv && zs5 > rzv) : (zs5 > r1 && zs5 < rzc);
    if (!hit5) begin
      part_sel = cspp_pkg::PART_FLAT;
    end else if (cap5) begin
      part_sel = cspp_pkg::PART_CAP;
    end else if (cyl5) begin
      part_sel = cspp_pkg::PART_CYL;
    end else begin
      part_sel = cspp_pkg::PART_RIM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= point.pos_x;
      y1 <= point.pos_y;
      z1 <= point.pos_z;
      x2 <= x1;
      y2 <= y1;
      z2 <= z1;
      for (int k = 0; k < 5; k++) begin
        hx2[k] <= DW'(x1) - axis_pos(GW'(k), 1'b0, r2, r6, r10);
        hy2[k] <= DW'(y1) - axis_pos(GW'(k), 1'b1, r2, r6, r10);
        box3[k] <= (ahx[k] < r2) && (ahy[k] < r2);
        mx3[k] <= KW'(ahx[k]);
        my3[k] <= KW'(ahy[k]);
        sx4[k] <= mx3[k] * mx3[k];
        sy4[k] <= my3[k] * my3[k];
      end
      x3 <= x2;
      y3 <= y2;
      z3 <= z2;
      x4 <= x3;
      y4 <= y3;
      z4 <= z3;
      box4 <= box3;
      lim4 <= k2r * k2r;
      x5 <= x4;
      y5 <= y4;
      z5 <= z4;
      reg5 <= reg_sel;
      hit5 <= hit_sel;
      x6 <= x5;
      y6 <= y5;
      z6 <= z5;
      reg6 <= reg5;
      hit6 <= hit5;
      part6 <= part_sel;
    end
  end

  always_comb begin
    cx6 = axis_pos(reg6, 1'b0, r2, r6, r10);
    cy6 = axis_pos(reg6, 1'b1, r2, r6, r10);
    cz6 = (reg6 == cspp_pkg::REGION_VILLUS) ? czv : r1;
    d1[0] = DW'(x6) - cx6;
    d1[1] = DW'(y6) - cy6;
    d1[2] = (part6 == cspp_pkg::PART_CAP) ? DW'(z6) - cz6 : '0;
    k1 = (part6 == cspp_pkg::PART_RIM) ? k2r : kr;
    pl1_in = {x6, y6, z6, reg6, part6, hit6};
  end

  cspp_proj #(
    .DW  (DW),
    .PLW (PLW1)
  ) u_proj_axis (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .d         (d1),
    .k         (k1),
    .in_pl     (pl1_in),
    .out_valid (v7),
    .q         (q7),
    .zero      (zero7),
    .out_pl    (pl7)
  );

  assign {x7, y7, z7, reg7} = pl7[PLW1-1:TW+1];

  always_comb begin
    rx7 = axis_pos(reg7, 1'b0, r2, r6, r10) + DW'(q7[0]);
    ry7 = axis_pos(reg7, 1'b1, r2, r6, r10) + DW'(q7[1]);
    rz7 = (reg7 == cspp_pkg::REGION_VILLUS) ? rzv : rzc;
    d2[0] = DW'(x7) - rx7;
    d2[1] = DW'(y7) - ry7;
    d2[2] = DW'(z7) - rz7;
    pl2_in = {pl7, q7[0], q7[1], q7[2], zero7};
  end

  cspp_proj #(
    .DW  (DW),
    .PLW (PLW2)
  ) u_proj_rim (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .d         (d2),
    .k         (kr),
    .in_pl     (pl2_in),
    .out_valid (v8),
    .q         (q8),
    .zero      (zero8),
    .out_pl    (pl8)
  );

  assign {x8, y8, z8, reg8, part8, hit8, q1x8, q1y8, q1z8, zero1_8} = pl8;

  always_comb begin
    cx8 = axis_pos(reg8, 1'b0, r2, r6, r10);
    cy8 = axis_pos(reg8, 1'b1, r2, r6, r10);
    cz8 = (reg8 == cspp_pkg::REGION_VILLUS) ? czv : r1;
    rz8 = (reg8 == cspp_pkg::REGION_VILLUS) ? rzv : rzc;
    rx8 = cx8 + DW'(q1x8);
    ry8 = cy8 + DW'(q1y8);
    degen8 = hit8 && (zero1_8 || (part8 == cspp_pkg::PART_RIM && zero8));
    ox = DW'(x8);
    oy = DW'(y8);
    oz = flat_z;
    if (hit8) begin
      if (degen8) begin
        oz = DW'(z8);
      end else begin
        case (part8)
          cspp_pkg::PART_CAP: begin
            ox = rx8;
            oy = ry8;
            oz = cz8 + DW'(q1z8);
          end
          cspp_pkg::PART_CYL: begin
            ox = rx8;
            oy = ry8;
            oz = DW'(z8);
          end
          default: begin
            ox = rx8 + DW'(q8[0]);
            oy = ry8 + DW'(q8[1]);
            oz = rz8 + DW'(q8[2]);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      surf.surf_x <= sat(ox);
      surf.surf_y <= sat(oy);
      surf.surf_z <= sat(oz);
      surf.region <= reg8;
      surf.part <= part8;
      surf.degenerate <= degen8;
    end
  end

endmodule
